@@ rtl/mdl_pkg.sv @@
// Shared constants, tables and types of the monthly day length pipeline.
package mdl_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int OUT_FRAC_BITS = 10;
  localparam int ROUND_SH      = 58 - OUT_FRAC_BITS;

  localparam logic signed [14:0] LAT_LIMIT   = 15'sd9000;
  localparam logic signed [18:0] RAD_Q30     = 19'sd187403;
  localparam logic signed [32:0] INV_GAIN    = 33'sd652032874;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic [31:0]        HOURS_Q28   = 32'd2050695827;
  localparam logic [63:0]        FULL_DAY    = 64'd24 << OUT_FRAC_BITS;
  localparam logic [63:0]        ROUND_HALF  = 64'd1 << (ROUND_SH - 1);

  // Tangent of the declination on the first day of each month, Q16.
  localparam logic signed [16:0] TAN_DECL [12] = '{
    -17'sd26759, -17'sd18900, -17'sd7183,  17'sd6741,   17'sd18900,  17'sd26759,
     17'sd26826,  17'sd19074,  17'sd6519, -17'sd6962,  -17'sd19420, -17'sd26955
  };

  localparam logic [31:0] ATAN_TBL [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1024, 32'd511, 32'd255,
    32'd127, 32'd64, 32'd31, 32'd15, 32'd7, 32'd4, 32'd1, 32'd1, 32'd0
  };

  typedef logic [1:0] pol_t;
  localparam pol_t POL_NONE  = 2'd0;
  localparam pol_t POL_DAY   = 2'd1;
  localparam pol_t POL_NIGHT = 2'd2;

  typedef struct packed {
    pol_t               pol;
    logic signed [33:0] p;
  } sq_side_t;

endpackage

@@ rtl/mdl_if.sv @@
// Valid/ready channel interfaces for input and result items.
interface mdl_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         month_number;
  logic signed [14:0] latitude_centideg;
  modport source(output valid, month_number, latitude_centideg, input ready);
  modport sink(input valid, month_number, latitude_centideg, output ready);
  modport monitor(input valid, ready, month_number, latitude_centideg);
endinterface

interface mdl_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] day_length;
  modport source(output valid, day_length, input ready);
  modport sink(input valid, day_length, output ready);
  modport monitor(input valid, ready, day_length);
endinterface

@@ rtl/mdl_rot.sv @@
// Pipelined rotation CORDIC giving cos and sin of the latitude angle.
module mdl_rot
  import mdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [32:0] in_z,
  input  logic signed [16:0] in_td,
  output logic               out_valid,
  output logic signed [32:0] out_x,
  output logic signed [32:0] out_y,
  output logic signed [16:0] out_td
);

  logic               v_r  [CORDIC_STAGES];
  logic signed [32:0] x_r  [CORDIC_STAGES];
  logic signed [32:0] y_r  [CORDIC_STAGES];
  logic signed [32:0] z_r  [CORDIC_STAGES];
  logic signed [16:0] td_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [32:0] ATAN = $signed({1'b0, ATAN_TBL[i]});
    logic               v_in;
    logic signed [32:0] x_in, y_in, z_in;
    logic signed [16:0] td_in;
    logic signed [32:0] x_nxt, y_nxt, z_nxt;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign x_in  = INV_GAIN;
      assign y_in  = '0;
      assign z_in  = in_z;
      assign td_in = in_td;
    end else begin : g_next
      assign v_in  = v_r[i-1];
      assign x_in  = x_r[i-1];
      assign y_in  = y_r[i-1];
      assign z_in  = z_r[i-1];
      assign td_in = td_r[i-1];
    end

    always_comb begin
      if (!z_in[32]) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - ATAN;
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]  <= x_nxt;
        y_r[i]  <= y_nxt;
        z_r[i]  <= z_nxt;
        td_r[i] <= td_in;
      end
    end
  end

  assign out_valid = v_r[CORDIC_STAGES-1];
  assign out_x     = x_r[CORDIC_STAGES-1];
  assign out_y     = y_r[CORDIC_STAGES-1];
  assign out_td    = td_r[CORDIC_STAGES-1];

endmodule

@@ rtl/mdl_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module mdl_isqrt
  import mdl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [61:0] in_v,
  input  sq_side_t    in_side,
  output logic        out_valid,
  output logic [30:0] out_root,
  output sq_side_t    out_side
);

  localparam int NSTG = 31;

  logic        v_r    [NSTG];
  logic [61:0] rem_r  [NSTG];
  logic [62:0] root_r [NSTG];
  sq_side_t    side_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam logic [62:0] BIT = 63'd1 << (60 - 2 * k);
    logic        v_in;
    logic [61:0] rem_in, rem_nxt;
    logic [62:0] root_in, root_nxt, trial;
    sq_side_t    side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_v;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = root_in + BIT;
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt  = rem_in - trial[61:0];
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_root  = root_r[NSTG-1][30:0];
  assign out_side  = side_r[NSTG-1];

endmodule

@@ rtl/mdl_vec.sv @@
// Pipelined vectoring CORDIC giving the hour angle from (-p, root).
module mdl_vec
  import mdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [30:0]        in_root,
  input  sq_side_t           in_side,
  output logic               out_valid,
  output logic signed [33:0] out_z,
  output pol_t               out_pol
);

  logic               v_r   [CORDIC_STAGES];
  logic signed [33:0] x_r   [CORDIC_STAGES];
  logic signed [33:0] y_r   [CORDIC_STAGES];
  logic signed [33:0] z_r   [CORDIC_STAGES];
  pol_t               pol_r [CORDIC_STAGES];

  // Start vector: (-p, root), pre-rotated by a quarter turn when -p is negative.
  logic signed [33:0] x0, y0, z0;
  always_comb begin
    if (in_side.p > 34'sd0) begin
      x0 = $signed({3'b000, in_root});
      y0 = in_side.p;
      z0 = HALF_PI_Q30;
    end else begin
      x0 = -in_side.p;
      y0 = $signed({3'b000, in_root});
      z0 = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [33:0] ATAN = $signed({2'b00, ATAN_TBL[i]});
    logic               v_in;
    logic signed [33:0] x_in, y_in, z_in;
    pol_t               pol_in;
    logic signed [33:0] x_nxt, y_nxt, z_nxt;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign x_in   = x0;
      assign y_in   = y0;
      assign z_in   = z0;
      assign pol_in = in_side.pol;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign pol_in = pol_r[i-1];
    end

    always_comb begin
      if (y_in > 34'sd0) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + ATAN;
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        z_r[i]   <= z_nxt;
        pol_r[i] <= pol_in;
      end
    end
  end

  assign out_valid = v_r[CORDIC_STAGES-1];
  assign out_z     = z_r[CORDIC_STAGES-1];
  assign out_pol   = pol_r[CORDIC_STAGES-1];

endmodule

@@ rtl/monthly_day_length_core.sv @@
// Pipeline stages in order: front 1, rotation CORDIC 16, product 1, squares 1,
// difference 1, square root 31, vectoring CORDIC 16, scale 2.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
module monthly_day_length_core
  import mdl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  mdl_in_if.sink          in_item,
  mdl_out_if.source       out_item
);

  logic en;
  logic out_valid_r;
  logic [14:0] day_r;

  assign en            = !out_valid_r || out_item.ready;
  assign in_item.ready = en;

  // Front stage: clamp inputs, table lookup, latitude to radians.
  logic [3:0]         mon_c;
  logic signed [14:0] lat_c;
  logic signed [33:0] zprod;
  logic               f_valid_r;
  logic signed [32:0] f_z_r;
  logic signed [16:0] f_td_r;

  always_comb begin
    if (in_item.month_number < 4'd1) begin
      mon_c = 4'd1;
    end else if (in_item.month_number > 4'd12) begin
      mon_c = 4'd12;
    end else begin
      mon_c = in_item.month_number;
    end
    if (in_item.latitude_centideg > LAT_LIMIT) begin
      lat_c = LAT_LIMIT;
    end else if (in_item.latitude_centideg < -LAT_LIMIT) begin
      lat_c = -LAT_LIMIT;
    end else begin
      lat_c = in_item.latitude_centideg;
    end
    zprod = lat_c * RAD_Q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_z_r  <= zprod[32:0];
      f_td_r <= TAN_DECL[mon_c - 4'd1];
    end
  end

  logic               r_valid;
  logic signed [32:0] r_x, r_y;
  logic signed [16:0] r_td;

  mdl_rot u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid_r),
    .in_z     (f_z_r),
    .in_td    (f_td_r),
    .out_valid(r_valid),
    .out_x    (r_x),
    .out_y    (r_y),
    .out_td   (r_td)
  );

  // Product stage: p = sin * tan(decl), cosine clamped at zero.
  logic signed [49:0] pprod;
  logic               p_valid_r;
  logic [31:0]        p_x_r;
  logic signed [33:0] p_p_r;

  assign pprod = r_y * r_td;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x_r <= r_x[32] ? 32'd0 : r_x[31:0];
      p_p_r <= pprod[49:16];
    end
  end

  // Square stage: polar tests and the two squares.
  logic signed [33:0] x_s, neg_p;
  logic [33:0]        p_abs;
  pol_t               pol_nxt;
  logic               s_valid_r;
  logic [63:0]        s_x2_r, s_p2_r;
  sq_side_t           s_side_r;

  always_comb begin
    x_s   = $signed({2'b00, p_x_r});
    neg_p = -p_p_r;
    p_abs = p_p_r[33] ? neg_p : p_p_r;
    if (p_p_r >= x_s) begin
      pol_nxt = POL_DAY;
    end else if (neg_p >= x_s) begin
      pol_nxt = POL_NIGHT;
    end else begin
      pol_nxt = POL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_x2_r       <= p_x_r * p_x_r;
      s_p2_r       <= p_abs[31:0] * p_abs[31:0];
      s_side_r.pol <= pol_nxt;
      s_side_r.p   <= p_p_r;
    end
  end

  // Difference stage: cos^2 - p^2, below 2^62 whenever it is used.
  logic        d_valid_r;
  logic [63:0] diff;
  logic [61:0] d_v_r;
  sq_side_t    d_side_r;

  assign diff = s_x2_r - s_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_v_r    <= diff[61:0];
      d_side_r <= s_side_r;
    end
  end

  logic        q_valid;
  logic [30:0] q_root;
  sq_side_t    q_side;

  mdl_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d_valid_r),
    .in_v     (d_v_r),
    .in_side  (d_side_r),
    .out_valid(q_valid),
    .out_root (q_root),
    .out_side (q_side)
  );

  logic               v_valid;
  logic signed [33:0] v_z;
  pol_t               v_pol;

  mdl_vec u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q_valid),
    .in_root  (q_root),
    .in_side  (q_side),
    .out_valid(v_valid),
    .out_z    (v_z),
    .out_pol  (v_pol)
  );

  // Scale stage: clamp the angle to [0, pi] and convert to hours.
  logic [31:0] ahou;
  logic        m_valid_r;
  logic [63:0] m_prod_r;
  pol_t        m_pol_r;

  always_comb begin
    if (v_z[33]) begin
      ahou = '0;
    end else if (v_z > PI_Q30) begin
      ahou = PI_Q30[31:0];
    end else begin
      ahou = v_z[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod_r <= ahou * HOURS_Q28;
      m_pol_r  <= v_pol;
    end
  end

  // Output register: rounding and the polar overrides.
  logic [63:0] res;

  always_comb begin
    case (m_pol_r)
      POL_DAY:   res = FULL_DAY;
      POL_NIGHT: res = '0;
      default:   res = (m_prod_r + ROUND_HALF) >> ROUND_SH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_r <= res[14:0];
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.day_length = day_r;

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.ready == (!out_item.valid || out_item.ready))
    else $error("input ready does not follow the output stall");

  a_polar_day: assert property (@(posedge clk) disable iff (!rst_n)
    (en && m_valid_r && m_pol_r == POL_DAY) |=>
      (out_item.valid && out_item.day_length == FULL_DAY[14:0]))
    else $error("polar day item did not give a full day");

  a_polar_night: assert property (@(posedge clk) disable iff (!rst_n)
    (en && m_valid_r && m_pol_r == POL_NIGHT) |=>
      (out_item.valid && out_item.day_length == 15'd0))
    else $error("polar night item did not give zero hours");
`endif

endmodule

@@ tb/mdl_day_length_checker.sv @@
// Checker that predicts the day length of each accepted item and compares results.
`timescale 1ns / 100ps
module mdl_day_length_checker
  import mdl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mdl_in_if.monitor  in_mon,
  mdl_out_if.monitor out_mon,
  output int         fail_count,
  output int         pending_days
);

  logic [14:0] day_queue[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [14:0] predict_day_length(logic [3:0] mon, logic signed [14:0] lat_in);
    int m;
    longint lat, td, x, y, z, nx, p, vx, vy, ang;
    longint unsigned diff, prod, res;
    m = mon;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    td = TAN_DECL[m - 1];
    lat = lat_in;
    if (lat > 9000) lat = 9000;
    if (lat < -9000) lat = -9000;
    x = INV_GAIN;
    y = 0;
    z = lat * RAD_Q30;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i % 32);
        y = y + shr_floor(x, i % 32);
        z -= longint'(ATAN_TBL[i % 32]);
      end else begin
        nx = x + shr_floor(y, i % 32);
        y = y - shr_floor(x, i % 32);
        z += longint'(ATAN_TBL[i % 32]);
      end
      x = nx;
    end
    if (x < 0) x = 0;
    p = shr_floor(y * td, 16);
    if (p >= x) begin
      res = FULL_DAY;
    end else if (-p >= x) begin
      res = 0;
    end else begin
      diff = longint'(x * x) - longint'(p * p);
      vy = longint'(root_floor(diff));
      vx = -p;
      if (vx < 0) begin
        x = vy;
        y = -vx;
        z = HALF_PI_Q30;
      end else begin
        x = vx;
        y = vy;
        z = 0;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (y > 0) begin
          nx = x + shr_floor(y, i % 32);
          y = y - shr_floor(x, i % 32);
          z += longint'(ATAN_TBL[i % 32]);
        end else begin
          nx = x - shr_floor(y, i % 32);
          y = y + shr_floor(x, i % 32);
          z -= longint'(ATAN_TBL[i % 32]);
        end
        x = nx;
      end
      ang = z;
      if (ang < 0) ang = 0;
      if (ang > PI_Q30) ang = PI_Q30;
      prod = longint'(ang) * longint'(HOURS_Q28);
      res = (prod + ROUND_HALF) >> ROUND_SH;
    end
    return res[14:0];
  endfunction

  logic [14:0] want;

  initial begin
    fail_count = 0;
    pending_days = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_mon.valid && in_mon.ready)
      day_queue.push_back(predict_day_length(in_mon.month_number, in_mon.latitude_centideg));
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (day_queue.size() == 0) begin
        fail_count <= fail_count + 1;
        $display("%0t: unexpected result item day_length=%0d", $time, out_mon.day_length);
      end else begin
        want = day_queue.pop_front();
        if (want !== out_mon.day_length) begin
          fail_count <= fail_count + 1;
          $display("%0t: day_length mismatch expected=%0d actual=%0d",
                   $time, want, out_mon.day_length);
        end
      end
    end
    pending_days <= day_queue.size();
  end

endmodule

@@ tb/monthly_day_length_core_tb.sv @@
// Top of the testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module monthly_day_length_core_tb;
  import mdl_pkg::*;

  localparam int LATENCY     = 69;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_days;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  int   quiet_cycles = 0;

  mdl_in_if  in_ch();
  mdl_out_if out_ch();

  monthly_day_length_core dut (.clk(clk), .rst_n(rst_n), .in_item(in_ch), .out_item(out_ch));

  mdl_day_length_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_days(pending_days)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.month_number = '0;
    in_ch.latitude_centideg = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Any handshake resets the watchdog.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [3:0] mon, logic signed [14:0] lat);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.month_number <= mon;
    in_ch.latitude_centideg <= lat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [3:0] mon;
    logic signed [14:0] lat;
    for (int k = 0; k < count; k++) begin
      mon = 4'($urandom_range(1, 12));
      case ($urandom_range(9))
        0: mon = 4'($urandom_range(15));
        default: ;
      endcase
      case ($urandom_range(9))
        0: lat = 15'($urandom);
        1: lat = ($urandom_range(1) ? 15'sd1 : -15'sd1) * $signed(15'($urandom_range(6000, 9000)));
        default: lat = $signed(15'($urandom_range(18000))) - 15'sd9000;
      endcase
      send_item(mon, lat);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: every month, field extremes, polar cases and saturation.
    for (int m = 0; m < 16; m++) send_item(m[3:0], 15'sd4500);
    send_item(4'd1, 15'sd0);
    send_item(4'd6, 15'sd9000);
    send_item(4'd6, -15'sd9000);
    send_item(4'd12, 15'sd8999);
    send_item(4'd1, 15'sh4000);
    send_item(4'd7, 15'sd16383);
    send_item(4'd3, -15'sd1);
    send_item(4'd9, 15'sd6700);
    send_item(4'd12, -15'sd6700);
    send_random(400);
    send_idle_pct = 52;
    send_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    send_random(400);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    send_random(400);
    // Long receiver hold-off while items keep coming, to fill the pipeline.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(400);
    join
    in_ch.valid <= 1'b0;
    while (pending_days != 0 && quiet_cycles < STALL_LIMIT) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending_days == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
